// ===== rtl/brfade_pkg.sv =====
package brfade_pkg;

    localparam int unsigned LEVEL_W       = 8;
    localparam int unsigned DUR_W         = 16;
    localparam int unsigned CFG_IDX_W     = 1;
    localparam int unsigned TIME_BITS_DEF = 16;
    localparam int unsigned LEN_RST_MS    = 1000;

    localparam logic [LEVEL_W-1:0] NORMAL_RST = 8'd255;
    localparam logic [LEVEL_W-1:0] DIMMED_RST = 8'd10;

    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_DIM      = 2'd1,
        ACT_BRIGHTEN = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORMAL = 1'd0,
        REG_DIMMED = 1'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        MODE_BRIGHT      = 4'b0001,
        MODE_DIMMING     = 4'b0010,
        MODE_DIMMED      = 4'b0100,
        MODE_BRIGHTENING = 4'b1000
    } fade_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } seq_state_t;

endpackage

// ===== rtl/brightness_fade_ramp.sv =====
// Linear contrast fade between normal_level and dimmed_level. Dim and brighten
// items start a fade of duration_ms milliseconds and give no result; each tick
// item during a fade gives one level, floor(range*elapsed/length) away from the
// starting level, with done_res set on the last. A tick mid-fade builds the
// product range*elapsed one range bit per cycle in ST_MUL, then an 8-bit
// restoring division gives one quotient bit per cycle in ST_DIV, then ST_OUT
// loads the level into the output register once any earlier result is taken.
// A tick that ends the fade skips both passes. The next item is taken while a
// result waits in the output register. Configuration writes are taken in any
// cycle and are meant for idle periods.
module brightness_fade_ramp
    import brfade_pkg::*;
#(
    parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]   cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_action,
    input  logic [DUR_W-1:0]     s_duration_ms,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [LEVEL_W-1:0]   m_level,
    output logic                 m_done_res
);

    localparam int unsigned PW    = TIME_BITS + LEVEL_W;
    localparam int unsigned CNT_W = $clog2(LEVEL_W);
    localparam logic [31:0] TIME_MAX = 32'((64'd1 << TIME_BITS) - 64'd1);
    localparam logic [TIME_BITS-1:0] LEN_RST =
        (32'(LEN_RST_MS) > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0] : TIME_BITS'(LEN_RST_MS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LEVEL_W - 1);

    seq_state_t            st_reg, st_next;
    fade_mode_t            mode_reg, mode_next;
    logic [TIME_BITS-1:0]  elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0]  length_reg, length_next;
    logic [LEVEL_W-1:0]    normal_reg, normal_next;
    logic [LEVEL_W-1:0]    dimmed_reg, dimmed_next;
    logic                  dim_reg, dim_next;
    logic                  done_reg, done_next;
    logic [LEVEL_W-1:0]    dig_reg, dig_next;
    logic [PW-1:0]         work_reg, work_next;
    logic [PW-1:0]         dsh_reg, dsh_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  m_valid_reg, m_valid_next;
    logic [LEVEL_W-1:0]    m_level_reg, m_level_next;
    logic                  m_done_reg, m_done_next;

    logic                  s_accept;
    logic                  fading;
    logic [TIME_BITS-1:0]  elapsed_inc;
    logic [TIME_BITS-1:0]  dur_sat;
    logic [LEVEL_W-1:0]    range;
    logic [31:0]           dur_ext;

    assign cfg_ready  = 1'b1;
    assign s_ready    = (st_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_level    = m_level_reg;
    assign m_done_res = m_done_reg;

    assign fading      = (mode_reg == MODE_DIMMING) || (mode_reg == MODE_BRIGHTENING);
    assign elapsed_inc = (32'(elapsed_reg) == TIME_MAX) ? elapsed_reg
                                                        : elapsed_reg + 1'b1;
    assign dur_ext     = 32'(s_duration_ms);
    assign dur_sat     = (dur_ext > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0]
                                              : dur_ext[TIME_BITS-1:0];
    assign range       = (normal_reg > dimmed_reg) ? normal_reg - dimmed_reg : '0;

    always_comb begin
        st_next      = st_reg;
        mode_next    = mode_reg;
        elapsed_next = elapsed_reg;
        length_next  = length_reg;
        normal_next  = normal_reg;
        dimmed_next  = dimmed_reg;
        dim_next     = dim_reg;
        done_next    = done_reg;
        dig_next     = dig_reg;
        work_next    = work_reg;
        dsh_next     = dsh_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_level_next = m_level_reg;
        m_done_next  = m_done_reg;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_NORMAL: normal_next = cfg_data;
                REG_DIMMED: dimmed_next = cfg_data;
                default:    ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (st_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (action_t'(s_action))
                        ACT_DIM: begin
                            if (mode_reg == MODE_BRIGHT || mode_reg == MODE_DIMMING) begin
                                length_next  = dur_sat;
                                elapsed_next = '0;
                                mode_next    = MODE_DIMMING;
                            end
                        end
                        ACT_BRIGHTEN: begin
                            if (mode_reg == MODE_DIMMED || mode_reg == MODE_BRIGHTENING) begin
                                length_next  = dur_sat;
                                elapsed_next = '0;
                                mode_next    = MODE_BRIGHTENING;
                            end
                        end
                        ACT_TICK: begin
                            if (fading) begin
                                elapsed_next = elapsed_inc;
                                dim_next     = (mode_reg == MODE_DIMMING);
                                if (elapsed_inc >= length_reg) begin
                                    done_next = 1'b1;
                                    mode_next = (mode_reg == MODE_DIMMING) ? MODE_DIMMED
                                                                           : MODE_BRIGHT;
                                    st_next   = ST_OUT;
                                end else begin
                                    done_next = 1'b0;
                                    dig_next  = range;
                                    work_next = '0;
                                    dsh_next  = PW'({length_reg, {(LEVEL_W-1){1'b0}}});
                                    cnt_next  = '0;
                                    st_next   = ST_MUL;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                // shift-add, range MSB first
                work_next = {work_reg[PW-2:0], 1'b0}
                          + (dig_reg[LEVEL_W-1] ? PW'(elapsed_reg) : '0);
                dig_next  = {dig_reg[LEVEL_W-2:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    cnt_next = '0;
                    st_next  = ST_DIV;
                end
            end
            ST_DIV: begin
                // quotient bits shift into dig_reg as the divisor shifts down
                if (work_reg >= dsh_reg) begin
                    work_next = work_reg - dsh_reg;
                    dig_next  = {dig_reg[LEVEL_W-2:0], 1'b1};
                end else begin
                    dig_next  = {dig_reg[LEVEL_W-2:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    cnt_next = '0;
                    st_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_done_next  = done_reg;
                    if (done_reg) begin
                        m_level_next = dim_reg ? dimmed_reg : normal_reg;
                    end else begin
                        m_level_next = dim_reg ? normal_reg - dig_reg : dimmed_reg + dig_reg;
                    end
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            mode_reg    <= MODE_BRIGHT;
            elapsed_reg <= '0;
            length_reg  <= LEN_RST;
            normal_reg  <= NORMAL_RST;
            dimmed_reg  <= DIMMED_RST;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
            length_reg  <= length_next;
            normal_reg  <= normal_next;
            dimmed_reg  <= dimmed_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dim_reg     <= dim_next;
        done_reg    <= done_next;
        dig_reg     <= dig_next;
        work_reg    <= work_next;
        dsh_reg     <= dsh_next;
        m_level_reg <= m_level_next;
        m_done_reg  <= m_done_next;
    end

`ifndef SYNTHESIS
    a_mul_to_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_MUL && cnt_reg == CNT_LAST) |=> (st_reg == ST_DIV))
        else $error("multiply pass did not hand over to divide");

    a_quot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_OUT && !done_reg) |-> (dig_reg < range || range == '0))
        else $error("ramp step not below range");

    a_elapsed_le_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_IDLE && fading) |-> (elapsed_reg <= length_reg))
        else $error("fade running past its length");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(st_reg == ST_OUT))
        else $error("result loaded outside output step");

    a_done_ends_fade: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_OUT && done_reg) |-> !fading)
        else $error("final level while fade still running");
`endif

endmodule
